// ===== rtl/keyframe_track_sampler_defines.svh =====
// Assertion macros for the keyframe track sampler.
// Used by the top level; relies on clk and arst_n in the including scope.
`ifndef KEYFRAME_TRACK_SAMPLER_DEFINES_SVH
`define KEYFRAME_TRACK_SAMPLER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define KTS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define KTS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/kts_pkg.sv =====
// Package for the keyframe track sampler: payload structs, sequencer states
// and register indexes. No dependencies.
`timescale 1ns / 1ps
package kts_pkg;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KEY_COUNT   = 2'd0,
		CFG_LOOP_LENGTH = 2'd1,
		CFG_STEP_MODE   = 2'd2
	} cfg_idx_t;

	typedef enum logic {
		MODE_WRITE  = 1'b0,
		MODE_SAMPLE = 1'b1
	} mode_t;

	typedef struct packed {
		logic               mode;
		logic [5:0]         key_index;
		logic [31:0]        key_time;
		logic signed [31:0] key_x;
		logic signed [31:0] key_y;
		logic signed [31:0] key_z;
		logic [31:0]        delta_time;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] value_x;
		logic signed [31:0] value_y;
		logic signed [31:0] value_z;
		logic               wrapped;
		logic [31:0]        play_time;
	} result_t;

	// One table entry.
	typedef struct packed {
		logic [31:0] t;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
	} key_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WRAP,
		ST_MOD,
		ST_RD0,
		ST_K0,
		ST_SRCH,
		ST_DIV,
		ST_MUL,
		ST_ACC,
		ST_OUT
	} state_t;

endpackage

// ===== rtl/kts_step_unit.sv =====
// Shared compare-and-subtract step for the restoring modulo and divider.
// Depends on nothing but its operands.
`timescale 1ns / 1ps
module kts_step_unit (
	input  logic [32:0] cand,
	input  logic [31:0] divisor,
	output logic        ge,
	output logic [32:0] rem_out
);

	// Subtract the divisor when the candidate remainder reaches it.
	always_comb begin
		ge = (cand >= {1'b0, divisor});
		rem_out = ge ? (cand - {1'b0, divisor}) : cand;
	end

endmodule

// ===== rtl/keyframe_track_sampler.sv =====
// Keyframe track sampler. A keyframe write is stored while idle and gives no result.
// A sample wraps the clock by restoring modulo past the loop length, reads
// the first key, searches segments, then divides and blends when interpolating,
// using the one-bit-per-cycle shared subtract unit and one table read per cycle.
// The result is shown for one cycle on done; the receiver cannot stall.
// Reset clears clock and sequencer, presets config; the key table is not cleared.
`timescale 1ns / 1ps
`include "keyframe_track_sampler_defines.svh"
module keyframe_track_sampler #(
	parameter int MAX_KEYS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  kts_pkg::cmd_t                   cmd,
	output logic                            done,
	output kts_pkg::result_t                result,
	input  logic                            cfg_we,
	input  logic [kts_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [kts_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import kts_pkg::*;

	localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int KW = $clog2(MAX_KEYS + 1);

	state_t state_q, state_d;

	logic [6:0]  key_count_q;
	logic [31:0] loop_length_q;
	logic        step_mode_q;
	logic [31:0] clock_q;
	logic        wrapped_q;

	key_t        mem [MAX_KEYS];
	key_t        rd_q, prev_q, nxt_q;
	logic [AW-1:0] rd_addr, idx_q;

	logic [32:0] rem_q;
	logic [31:0] div_q, sh_q;
	logic [4:0]  cnt_q;
	logic [1:0]  comp_q;
	logic signed [50:0] prod_q;
	result_t     res_q;

	logic [32:0] cand, rem_new;
	logic        ge;
	logic [31:0] kc32, n32;
	logic [KW-1:0] n_eff;
	logic        accept, seg_hit, last_seg;
	logic [32:0] sat_sum;
	logic [31:0] span, a_sel, b_sel, blend;
	logic signed [32:0] diff;
	logic signed [50:0] prod_sh;

	// Effective key count: zero acts as one, large values clamp.
	always_comb begin
		kc32 = 32'(key_count_q);
		if (kc32 == 32'd0) begin
			n32 = 32'd1;
		end else if (kc32 > 32'(MAX_KEYS)) begin
			n32 = 32'(MAX_KEYS);
		end else begin
			n32 = kc32;
		end
		n_eff = n32[KW-1:0];
	end

	assign accept = start && !busy;
	assign sat_sum = {1'b0, clock_q} + {1'b0, cmd.delta_time};

	// Segment test on the previous and current keys.
	always_comb begin
		seg_hit = (prev_q.t <= clock_q) && (clock_q <= rd_q.t);
		last_seg = ((KW)'(idx_q) + (KW)'(1)) == n_eff;
		span = rd_q.t - prev_q.t;
	end

	// Operand select for the shared step unit.
	always_comb begin
		if (state_q == ST_MOD) begin
			cand = {rem_q[31:0], sh_q[31]};
		end else if (cnt_q == 5'd0) begin
			cand = rem_q;
		end else begin
			cand = {rem_q[31:0], 1'b0};
		end
	end

	kts_step_unit u_step (
		.cand    (cand),
		.divisor (div_q),
		.ge      (ge),
		.rem_out (rem_new)
	);

	// Component select and blend for the lerp.
	always_comb begin
		case (comp_q)
			2'd0:    begin a_sel = prev_q.x; b_sel = nxt_q.x; end
			2'd1:    begin a_sel = prev_q.y; b_sel = nxt_q.y; end
			default: begin a_sel = prev_q.z; b_sel = nxt_q.z; end
		endcase
		diff = $signed({b_sel[31], b_sel}) - $signed({a_sel[31], a_sel});
		prod_sh = prod_q >>> 16;
		blend = a_sel + prod_sh[31:0];
	end

	// Table read address.
	always_comb begin
		case (state_q)
			ST_K0:   rd_addr = (AW)'(1);
			ST_SRCH: rd_addr = idx_q + (AW)'(1);
			default: rd_addr = '0;
		endcase
	end

	// Key table: written on a keyframe transfer, read once per cycle.
	always_ff @(posedge clk) begin
		if (accept && cmd.mode == MODE_WRITE && 32'(cmd.key_index) < 32'(MAX_KEYS)) begin
			mem[(AW)'(cmd.key_index)] <= '{cmd.key_time, cmd.key_x, cmd.key_y, cmd.key_z};
		end
		rd_q <= mem[rd_addr];
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= 7'd1;
			loop_length_q <= 32'd65536;
			step_mode_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_KEY_COUNT:   key_count_q <= cfg_data[6:0];
				CFG_LOOP_LENGTH: loop_length_q <= cfg_data;
				CFG_STEP_MODE:   step_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept && cmd.mode == MODE_SAMPLE) state_d = ST_WRAP;
			ST_WRAP: begin
				if (loop_length_q != 32'd0 && clock_q > loop_length_q) state_d = ST_MOD;
				else state_d = ST_RD0;
			end
			ST_MOD:  if (cnt_q == 5'd31) state_d = ST_RD0;
			ST_RD0:  state_d = ST_K0;
			ST_K0: begin
				if (n_eff == (KW)'(1) || clock_q <= rd_q.t) state_d = ST_OUT;
				else state_d = ST_SRCH;
			end
			ST_SRCH: begin
				if (seg_hit) begin
					if (step_mode_q || span == 32'd0) state_d = ST_OUT;
					else state_d = ST_DIV;
				end else if (last_seg) begin
					state_d = ST_OUT;
				end
			end
			ST_DIV:  if (cnt_q == 5'd16) state_d = ST_MUL;
			ST_MUL:  state_d = ST_ACC;
			ST_ACC:  if (comp_q == 2'd2) state_d = ST_OUT; else state_d = ST_MUL;
			ST_OUT:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		busy = (state_q != ST_IDLE);
		done = (state_q == ST_OUT);
		result = res_q;
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			clock_q <= '0;
			wrapped_q <= 1'b0;
			cnt_q <= '0;
			comp_q <= '0;
			idx_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (accept && cmd.mode == MODE_SAMPLE) begin
						clock_q <= sat_sum[32] ? 32'hFFFF_FFFF : sat_sum[31:0];
						wrapped_q <= 1'b0;
					end
				end
				ST_WRAP: begin
					cnt_q <= '0;
					if (loop_length_q != 32'd0 && clock_q > loop_length_q) wrapped_q <= 1'b1;
				end
				ST_MOD: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) clock_q <= rem_new[31:0];
				end
				ST_K0: idx_q <= (AW)'(1);
				ST_SRCH: begin
					cnt_q <= '0;
					comp_q <= '0;
					if (!seg_hit && !last_seg) idx_q <= idx_q + (AW)'(1);
				end
				ST_DIV:  cnt_q <= cnt_q + 5'd1;
				ST_ACC:  comp_q <= comp_q + 2'd1;
				default: ;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_WRAP: begin
				rem_q <= '0;
				sh_q <= clock_q;
				div_q <= loop_length_q;
			end
			ST_MOD: begin
				rem_q <= rem_new;
				sh_q <= {sh_q[30:0], 1'b0};
			end
			ST_K0: begin
				prev_q <= rd_q;
				res_q <= '{rd_q.x, rd_q.y, rd_q.z, wrapped_q, clock_q};
			end
			ST_SRCH: begin
				nxt_q <= rd_q;
				rem_q <= {1'b0, clock_q - prev_q.t};
				div_q <= span;
				sh_q <= '0;
				if (seg_hit) begin
					res_q <= '{prev_q.x, prev_q.y, prev_q.z, wrapped_q, clock_q};
				end else begin
					res_q <= '{rd_q.x, rd_q.y, rd_q.z, wrapped_q, clock_q};
					prev_q <= rd_q;
				end
			end
			ST_DIV: begin
				rem_q <= rem_new;
				sh_q <= {sh_q[30:0], ge};
			end
			ST_MUL: prod_q <= diff * $signed({1'b0, sh_q[16:0]});
			ST_ACC: begin
				case (comp_q)
					2'd0:    res_q.value_x <= blend;
					2'd1:    res_q.value_y <= blend;
					default: res_q.value_z <= blend;
				endcase
			end
			default: ;
		endcase
	end

	`KTS_ASSERT_NEXT(a_sample_busy, accept && cmd.mode == MODE_SAMPLE, busy, "sample did not start")
	`KTS_ASSERT_NEXT(a_write_quick, accept && cmd.mode == MODE_WRITE, !busy, "write held block")
	`KTS_ASSERT_NEXT(a_done_pulse, done, !done, "done longer than one cycle")
	`KTS_ASSERT_NOW(a_wrap_range, done && result.wrapped, result.play_time < loop_length_q, "wrap out of range")

endmodule

// ===== verif/keyframe_track_sampler_tb.sv =====
// Self-checking testbench for keyframe_track_sampler: directed rows, then random phases.
// Depends on kts_pkg and the keyframe_track_sampler top level.
`timescale 1ns / 1ps
module keyframe_track_sampler_tb;
	import kts_pkg::*;

	localparam int TABLE_DEPTH = 64;
	localparam int RANDOM_ITEMS = 1900;
	localparam int STALL_LIMIT = 4000;

	typedef enum logic {
		ROW_CMD,
		ROW_CFG
	} row_kind_t;

	typedef struct {
		row_kind_t kind;
		cmd_t      item;
		cfg_idx_t  reg_idx;
		logic [31:0] reg_val;
		bit        typed;
		result_t   typed_res;
	} row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	cmd_t cmd;
	logic done;
	result_t result;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	keyframe_track_sampler i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Predictor copy of the block's state and registers.
	logic [6:0]  pr_count;
	logic [31:0] pr_loop;
	logic        pr_step;
	logic [31:0] pr_clock;
	logic [31:0] pr_time [TABLE_DEPTH];
	logic [31:0] pr_x [TABLE_DEPTH];
	logic [31:0] pr_y [TABLE_DEPTH];
	logic [31:0] pr_z [TABLE_DEPTH];

	result_t pending_samples[$];
	row_t stim_rows[$];
	int fail_count;
	int stall_cycles;
	int item_count;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Blend one component: a + floor((b - a) * f / 65536).
	function automatic logic [31:0] blend(logic [31:0] a, logic [31:0] b, logic [31:0] f);
		longint sa, prod;
		sa = longint'($signed(a));
		prod = (longint'($signed(b)) - sa) * longint'(f);
		return 32'(sa + (prod >>> 16));
	endfunction

	// Advance the clock, pick the segment and return the sampled vector.
	function automatic result_t sample_track(logic [31:0] delta);
		result_t r;
		longint unsigned sum;
		int n, sel;
		bit found;
		logic [31:0] span, el, frac;
		sum = longint'(pr_clock) + longint'(delta);
		pr_clock = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
		r.wrapped = 1'b0;
		if (pr_loop != 0 && pr_clock > pr_loop) begin
			r.wrapped = 1'b1;
			pr_clock = pr_clock % pr_loop;
		end
		r.play_time = pr_clock;
		n = (pr_count == 0) ? 1 : (pr_count > TABLE_DEPTH) ? TABLE_DEPTH : pr_count;
		if (n == 1 || pr_clock <= pr_time[0]) begin
			r.value_x = pr_x[0];
			r.value_y = pr_y[0];
			r.value_z = pr_z[0];
			return r;
		end
		found = 0;
		sel = n - 1;
		for (int i = 0; i + 1 < n; i++) begin
			if (pr_time[i] <= pr_clock && pr_clock <= pr_time[i+1]) begin
				sel = i;
				found = 1;
				break;
			end
		end
		if (!found || pr_step) begin
			r.value_x = pr_x[sel];
			r.value_y = pr_y[sel];
			r.value_z = pr_z[sel];
		end else begin
			span = pr_time[sel+1] - pr_time[sel];
			el = pr_clock - pr_time[sel];
			frac = (span == 0) ? 32'd0 : 32'(({32'd0, el} << 16) / span);
			r.value_x = blend(pr_x[sel], pr_x[sel+1], frac);
			r.value_y = blend(pr_y[sel], pr_y[sel+1], frac);
			r.value_z = blend(pr_z[sel], pr_z[sel+1], frac);
		end
		return r;
	endfunction

	function automatic void add_write(int idx, logic [31:0] t, logic [31:0] x,
			logic [31:0] y, logic [31:0] z);
		row_t r;
		r = '{kind: ROW_CMD, item: '0, reg_idx: CFG_KEY_COUNT, reg_val: '0,
			typed: 1'b0, typed_res: '0};
		r.item = '{mode: MODE_WRITE, key_index: 6'(idx), key_time: t, key_x: x,
			key_y: y, key_z: z, delta_time: $urandom};
		stim_rows.push_back(r);
	endfunction

	function automatic void add_sample(logic [31:0] delta, bit typed = 0,
			logic [31:0] x = 0, logic [31:0] y = 0, logic [31:0] z = 0,
			logic w = 0, logic [31:0] pt = 0);
		row_t r;
		r = '{kind: ROW_CMD, item: '0, reg_idx: CFG_KEY_COUNT, reg_val: '0,
			typed: 1'b0, typed_res: '0};
		r.item = '{mode: MODE_SAMPLE, key_index: 6'($urandom), key_time: $urandom,
			key_x: $urandom, key_y: $urandom, key_z: $urandom, delta_time: delta};
		r.typed = typed;
		r.typed_res = '{value_x: x, value_y: y, value_z: z, wrapped: w, play_time: pt};
		stim_rows.push_back(r);
	endfunction

	function automatic void add_cfg(cfg_idx_t idx, logic [31:0] val);
		row_t r;
		r = '{kind: ROW_CFG, item: '0, reg_idx: CFG_KEY_COUNT, reg_val: '0,
			typed: 1'b0, typed_res: '0};
		r.reg_idx = idx;
		r.reg_val = val;
		stim_rows.push_back(r);
	endfunction

	// Wait for the block to drain, then write one register.
	task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
		start <= 1'b0;
		while (pending_samples.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		while (busy) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_KEY_COUNT:   pr_count = val[6:0];
			CFG_LOOP_LENGTH: pr_loop = val;
			CFG_STEP_MODE:   pr_step = val[0];
			default: ;
		endcase
	endtask

	// Hold one command until the block takes it, then update the predictor.
	task automatic send_item(cmd_t c, bit typed, result_t typed_res);
		result_t r;
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
		item_count++;
		if (c.mode == MODE_WRITE) begin
			pr_time[c.key_index] = c.key_time;
			pr_x[c.key_index] = c.key_x;
			pr_y[c.key_index] = c.key_y;
			pr_z[c.key_index] = c.key_z;
		end else begin
			r = sample_track(c.delta_time);
			pending_samples.push_back(typed ? typed_res : r);
		end
		// Random sender gaps, except through one long burst.
		if ((item_count < 700 || item_count > 1000) && $urandom_range(0, 99) < 14) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic run_rows();
		foreach (stim_rows[i]) begin
			if (stim_rows[i].kind == ROW_CFG)
				write_reg(stim_rows[i].reg_idx, stim_rows[i].reg_val);
			else
				send_item(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].typed_res);
		end
		stim_rows.delete();
	endtask

	// Rewrite the whole table with mostly ascending times.
	function automatic logic [31:0] fill_table(logic [31:0] gap);
		logic [31:0] t;
		t = $urandom_range(0, gap);
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if ($urandom_range(0, 19) == 0)
				add_write(i, $urandom, $urandom, $urandom, $urandom);
			else
				add_write(i, t, $urandom, $urandom, $urandom);
			if ($urandom_range(0, 9) != 0)
				t = (t > 32'hFFFF_FFFF - gap) ? 32'hFFFF_FFFF : t + $urandom_range(0, gap);
		end
		return t;
	endfunction

	// Result check against the oldest expectation.
	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && done) begin
			if (pending_samples.size() == 0) begin
				$error("result transfer with no sample outstanding");
				fail_count++;
			end else begin
				exp_r = pending_samples.pop_front();
				if (result.value_x !== exp_r.value_x) begin
					$error("value_x expected %h actual %h", exp_r.value_x, result.value_x);
					fail_count++;
				end
				if (result.value_y !== exp_r.value_y) begin
					$error("value_y expected %h actual %h", exp_r.value_y, result.value_y);
					fail_count++;
				end
				if (result.value_z !== exp_r.value_z) begin
					$error("value_z expected %h actual %h", exp_r.value_z, result.value_z);
					fail_count++;
				end
				if (result.wrapped !== exp_r.wrapped) begin
					$error("wrapped expected %b actual %b", exp_r.wrapped, result.wrapped);
					fail_count++;
				end
				if (result.play_time !== exp_r.play_time) begin
					$error("play_time expected %h actual %h", exp_r.play_time,
						result.play_time);
					fail_count++;
				end
			end
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || cfg_we) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		logic [31:0] gap, track_end, lp;
		int phase, n_req, cnt;
		fail_count = 0;
		item_count = 0;
		stall_cycles = 0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		pr_count = 7'd1;
		pr_loop = 32'd65536;
		pr_step = 1'b0;
		pr_clock = '0;
		foreach (pr_time[i]) begin
			pr_time[i] = '0;
			pr_x[i] = '0;
			pr_y[i] = '0;
			pr_z[i] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows: single key, wrap, saturation, zero-length and unsorted segments.
		add_write(0, 32'h0000_8000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
		add_sample(32'h0, 1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0, 32'h0);
		add_sample(32'h0001_0000, 1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0,
			32'h0001_0000);
		add_sample(32'h1, 1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b1, 32'h1);
		add_sample(32'hFFFF_FFFF, 1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b1,
			32'h0000_FFFF);
		add_write(1, 32'h0002_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_2345);
		add_write(2, 32'h0002_0000, 32'h1, 32'h2, 32'h3);
		add_write(3, 32'h0001_0000, 32'hFFFF_0000, 32'h0, 32'h7);
		add_write(63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_cfg(CFG_KEY_COUNT, 32'd4);
		add_cfg(CFG_LOOP_LENGTH, 32'd0);
		add_sample(32'h0);
		add_sample(32'h0001_0000);
		add_sample(32'h1);
		add_sample(32'h0);
		add_sample(32'h1);
		add_cfg(CFG_STEP_MODE, 32'd1);
		add_sample(32'hFFFF_FFFF);
		add_cfg(CFG_KEY_COUNT, 32'd0);
		add_cfg(CFG_LOOP_LENGTH, 32'hFFFF_FFFF);
		add_sample(32'h5, 1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0, 32'hFFFF_FFFF);
		run_rows();

		// Random phases: new settings, sometimes a fresh table, then mixed traffic.
		phase = 0;
		track_end = 32'h0010_0000;
		gap = 32'h4000;
		while (item_count < RANDOM_ITEMS) begin
			if (phase == 0 || $urandom_range(0, 2) == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? 32'h0400_0000 : $urandom_range(1, 32'h8000);
				track_end = fill_table(gap);
			end
			case ($urandom_range(0, 9))
				0: cnt = 0;
				1: cnt = 1;
				2: cnt = 127;
				3: cnt = 64;
				default: cnt = $urandom_range(2, 64);
			endcase
			case ($urandom_range(0, 9))
				0: lp = 32'd0;
				1: lp = 32'hFFFF_FFFF;
				2: lp = 32'd1;
				default: lp = $urandom_range(1, (track_end > 32'h7FFF_FFFF) ?
					32'hFFFF_FFFF : track_end + track_end / 2 + 1);
			endcase
			add_cfg(CFG_KEY_COUNT, cnt);
			add_cfg(CFG_LOOP_LENGTH, lp);
			add_cfg(CFG_STEP_MODE, $urandom_range(0, 1));
			n_req = $urandom_range(100, 180);
			for (int k = 0; k < n_req; k++) begin
				if ($urandom_range(0, 3) == 0)
					add_write($urandom_range(0, TABLE_DEPTH - 1),
						$urandom_range(0, track_end), $urandom, $urandom, $urandom);
				else case ($urandom_range(0, 19))
					0: add_sample(32'h0);
					1, 2: add_sample($urandom);
					default: add_sample($urandom_range(0, gap * 4 + 1));
				endcase
			end
			run_rows();
			// Sender holds off until every sample result has returned.
			start <= 1'b0;
			while (pending_samples.size() != 0) @(posedge clk);
			phase++;
		end

		start <= 1'b0;
		while (pending_samples.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/kts_pkg.sv
rtl/kts_step_unit.sv
rtl/keyframe_track_sampler.sv
verif/keyframe_track_sampler_tb.sv
